FILE: design/tlc_pkg.sv
// Shared constants and types of the two-level cache tag block.
`default_nettype none

package tlc_pkg;

  // Field widths of the channels.
  localparam int ADDR_W     = 32;
  localparam int TIME_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Row counter of the clearing pass; wide enough for the largest set count.
  localparam int CLR_W = 15;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ICACHE_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DCACHE_ENABLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ICACHE_LATENCY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DCACHE_LATENCY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_LATENCY     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_LATENCY = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_INCLUSIVE_MODE = 3'd7;

  // Smallest line offset that the address split uses.
  localparam logic [2:0] MIN_OFFSET = 3'd2;

  // Owner of an L2 line.
  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_INSTR = 2'd1;
  localparam logic [1:0] SRC_DATA  = 2'd2;

  // Operations the sequencer issues to one L1 tag array.
  typedef struct packed {
    logic             clr;
    logic [CLR_W-1:0] clr_row;
    logic             rd;
    logic             hit_wr;
    logic             inv_wr;
    logic             fill_wr;
  } tlc_l1_ctl_t;

endpackage

`default_nettype wire

FILE: design/tlc_if.sv
// Handshake interfaces of the request, response and configuration channels.
`default_nettype none

interface tlc_req_if import tlc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic              mode;
  modport source (output valid, output address, output mode, input ready);
  modport sink (input valid, input address, input mode, output ready);
endinterface

interface tlc_rsp_if import tlc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] access_time;
  logic              l1_hit;
  logic              l2_used;
  logic              l2_hit;
  logic              back_invalidated;
  modport source (output valid, output access_time, output l1_hit, output l2_used,
                  output l2_hit, output back_invalidated, input ready);
  modport sink (input valid, input access_time, input l1_hit, input l2_used,
                input l2_hit, input back_invalidated, output ready);
endinterface

interface tlc_cfg_if import tlc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/two_level_lru_cache_tags.sv
// Top level of the two-level cache tag block: sequencer, L2 tag array and configuration.
//
// Usage: the request channel carries a byte address and a port (0 fetch, 1 data).
// The response channel returns one beat per request: access time, L1 hit, L2 used,
// L2 hit and whether an L1 line was back-invalidated for inclusion.
// The configuration channel writes one register per beat and is always ready; the
// user must write it only while no request is in flight; the block does not enforce it.
// Each cache keeps one RAM row per set holding tag, valid bit and LRU age of all ways;
// every access reads the rows, and each row that it changes is updated and written back.
// From the request beat the sequencer enters LOOK. An L1 hit, or an L1 bypass without
// back-invalidation, goes on to DONE; an L1 miss goes through FILL to DONE. A
// back-invalidation adds BINV, then REREAD before FILL, or goes straight to DONE on a
// bypass. One request is in flight at a time, so a new one is taken once the last
// response is in the output register.
// After reset a clearing pass writes every set row, stepping a row counter up to the
// largest of I_SETS, D_SETS and L2_SETS (rounded down to a power of two); requests
// wait during it, configuration writes do not.
// If the receiver stalls, the response holds in the output register and the
// next finished access waits behind it.
`default_nettype none

module two_level_lru_cache_tags import tlc_pkg::*; #(
  parameter int I_SETS  = 64,
  parameter int I_WAYS  = 4,
  parameter int D_SETS  = 64,
  parameter int D_WAYS  = 4,
  parameter int L2_SETS = 256,
  parameter int L2_WAYS = 8
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  tlc_req_if.sink   req_i,
  tlc_rsp_if.source rsp_o,
  tlc_cfg_if.sink   cfg_i
);

  localparam int I_ROWS = 1 << ($clog2(I_SETS + 1) - 1);
  localparam int D_ROWS = 1 << ($clog2(D_SETS + 1) - 1);
  localparam int SB     = $clog2(L2_SETS + 1) - 1;
  localparam int ROWS   = 1 << SB;
  localparam int L1_MAX = (I_ROWS > D_ROWS) ? I_ROWS : D_ROWS;
  localparam int MAXR   = (L1_MAX > ROWS) ? L1_MAX : ROWS;
  localparam int RAW    = (SB > 0) ? SB : 1;
  localparam int AW     = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
  localparam int TW     = ADDR_W - 2 - SB;
  localparam int EW     = 2 + 1 + AW + TW;
  localparam int RW     = L2_WAYS * EW;
  localparam logic [ADDR_W-1:0] SMASK = (ADDR_W'(1) << SB) - ADDR_W'(1);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LOOK   = 3'd2;
  localparam logic [2:0] ST_BINV   = 3'd3;
  localparam logic [2:0] ST_REREAD = 3'd4;
  localparam logic [2:0] ST_FILL   = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [CLR_W-1:0] clr_q, clr_d;

  // Configuration registers.
  logic [2:0] offset_q;
  logic       ien_q, den_q, incl_q;
  logic [7:0] ilat_q, dlat_q, l2lat_q;
  logic [9:0] memlat_q;

  // Per-access registers.
  logic [ADDR_W-1:0] addr_q, vaddr_q, vaddr_c;
  logic              mode_q;
  logic [1:0]        vsrc_q;
  logic [TIME_W-1:0] time_q, time_c;
  logic              l1hit_q, l2used_q, l2hit_q, binv_q;

  // Response register.
  logic              rsp_valid_q;
  logic [TIME_W-1:0] rsp_time_q;
  logic              rsp_l1hit_q, rsp_l2used_q, rsp_l2hit_q, rsp_binv_q;

  logic [2:0] off;
  logic       accept, l1en, l1hit_c, go_binv, rsp_load;
  logic       i_hit, d_hit;
  tlc_l1_ctl_t ictl, dctl;
  logic [ADDR_W-1:0] i_raddr, d_raddr, i_addr, d_addr;

  assign off    = (offset_q < MIN_OFFSET) ? MIN_OFFSET : offset_q;
  assign accept = req_i.valid && req_i.ready;
  assign l1en   = mode_q ? den_q : ien_q;
  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= 3'd6;
      ien_q    <= 1'b1;
      den_q    <= 1'b1;
      ilat_q   <= 8'd1;
      dlat_q   <= 8'd1;
      l2lat_q  <= 8'd10;
      memlat_q <= 10'd100;
      incl_q   <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_OFFSET_BITS:    offset_q <= cfg_i.data[2:0];
        CFG_ICACHE_ENABLE:  ien_q    <= cfg_i.data[0];
        CFG_DCACHE_ENABLE:  den_q    <= cfg_i.data[0];
        CFG_ICACHE_LATENCY: ilat_q   <= cfg_i.data[7:0];
        CFG_DCACHE_LATENCY: dlat_q   <= cfg_i.data[7:0];
        CFG_L2_LATENCY:     l2lat_q  <= cfg_i.data[7:0];
        CFG_MEMORY_LATENCY: memlat_q <= cfg_i.data;
        CFG_INCLUSIVE_MODE: incl_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // L2 tag array: row address, row unpacking and way selection.
  logic [RW-1:0]  l2_rdata, l2_wdata;
  logic           l2_we;
  logic [RAW-1:0] l2_rrow, l2_orow, l2_wrow;
  logic [TW-1:0]  l2_otag;
  logic [L2_WAYS-1:0] l2_vld, l2_mt, l2_nvld;
  logic [AW-1:0]  l2_age  [L2_WAYS];
  logic [AW-1:0]  l2_nage [L2_WAYS];
  logic [TW-1:0]  l2_tag  [L2_WAYS];
  logic [TW-1:0]  l2_ntag [L2_WAYS];
  logic [1:0]     l2_src  [L2_WAYS];
  logic [1:0]     l2_nsrc [L2_WAYS];
  logic [AW-1:0]  l2_hway, l2_vway, l2_sel;
  logic           l2_hit, l2_evict;
  logic [ADDR_W-1:0] l2_rsh, l2_osh;

  assign l2_rsh  = (req_i.address >> off) & SMASK;
  assign l2_osh  = (addr_q >> off) & SMASK;
  assign l2_rrow = l2_rsh[RAW-1:0];
  assign l2_orow = l2_osh[RAW-1:0];
  assign l2_otag = TW'(addr_q >> (32'(off) + 32'(SB)));

  always_comb begin
    for (int w = 0; w < L2_WAYS; w++) begin
      l2_src[w] = l2_rdata[w*EW + EW - 1 -: 2];
      l2_vld[w] = l2_rdata[w*EW + TW + AW];
      l2_age[w] = l2_rdata[w*EW + TW +: AW];
      l2_tag[w] = l2_rdata[w*EW +: TW];
      l2_mt[w]  = l2_vld[w] && (l2_tag[w] == l2_otag);
    end
  end

  assign l2_hit   = |l2_mt;
  assign l2_evict = &l2_vld;

  always_comb begin
    l2_hway = '0;
    l2_vway = '0;
    for (int w = L2_WAYS - 1; w >= 0; w--) begin
      if (l2_mt[w]) begin
        l2_hway = AW'(w);
      end
      if (l2_age[w] == '0) begin
        l2_vway = AW'(w);
      end
    end
    for (int w = L2_WAYS - 1; w >= 0; w--) begin
      if (!l2_vld[w]) begin
        l2_vway = AW'(w);
      end
    end
  end

  // L2 row update: promote on a hit, refill the victim on a miss, reset row when clearing.
  always_comb begin
    l2_nvld = l2_vld;
    l2_ntag = l2_tag;
    l2_nage = l2_age;
    l2_nsrc = l2_src;
    l2_sel  = l2_hit ? l2_hway : l2_vway;
    for (int j = 0; j < L2_WAYS; j++) begin
      if (l2_age[j] > l2_age[l2_sel]) begin
        l2_nage[j] = l2_age[j] - AW'(1);
      end
    end
    l2_nage[l2_sel] = AW'(L2_WAYS - 1);
    if (!l2_hit) begin
      l2_ntag[l2_sel] = l2_otag;
      l2_nvld[l2_sel] = 1'b1;
      l2_nsrc[l2_sel] = l1en ? (mode_q ? SRC_DATA : SRC_INSTR) : SRC_NONE;
    end
    if (state_q == ST_CLEAR) begin
      for (int j = 0; j < L2_WAYS; j++) begin
        l2_nvld[j] = 1'b0;
        l2_ntag[j] = '0;
        l2_nage[j] = AW'(j);
        l2_nsrc[j] = SRC_NONE;
      end
    end
    for (int j = 0; j < L2_WAYS; j++) begin
      l2_wdata[j*EW +: EW] = {l2_nsrc[j], l2_nvld[j], l2_nage[j], l2_ntag[j]};
    end
  end

  // Hit decision, victim address and latency of the access being looked up.
  assign l1hit_c = l1en && (mode_q ? d_hit : i_hit);
  assign go_binv = !l1hit_c && !l2_hit && l2_evict && incl_q &&
                   (l2_src[l2_vway] != SRC_NONE);
  assign vaddr_c = ((ADDR_W'(l2_tag[l2_vway]) << SB) | ADDR_W'(l2_orow)) << off;

  always_comb begin
    time_c = '0;
    if (l1en) begin
      time_c = TIME_W'(mode_q ? dlat_q : ilat_q);
    end
    if (!l1hit_c) begin
      time_c = time_c + TIME_W'(l2lat_q);
      if (!l2_hit) begin
        time_c = time_c + TIME_W'(memlat_q);
      end
    end
  end

  assign l2_we   = ((state_q == ST_CLEAR) && (32'(clr_q) < 32'(ROWS))) ||
                   ((state_q == ST_LOOK) && !l1hit_c);
  assign l2_wrow = (state_q == ST_CLEAR) ? clr_q[RAW-1:0] : l2_orow;

  tlc_ram #(
    .WIDTH (RW),
    .DEPTH (ROWS)
  ) u_l2_ram (
    .clk_i   (clk_i),
    .we_i    (l2_we),
    .waddr_i (l2_wrow),
    .wdata_i (l2_wdata),
    .re_i    (accept),
    .raddr_i (l2_rrow),
    .rdata_o (l2_rdata)
  );

  // L1 commands: both arrays are read at request time, the back-invalidation
  // reads the owning array at the victim address.
  always_comb begin
    ictl = '0;
    dctl = '0;
    ictl.clr     = (state_q == ST_CLEAR);
    dctl.clr     = (state_q == ST_CLEAR);
    ictl.clr_row = clr_q;
    dctl.clr_row = clr_q;
    ictl.rd = accept || ((state_q == ST_LOOK) && go_binv && (l2_src[l2_vway] == SRC_INSTR))
              || ((state_q == ST_REREAD) && !mode_q);
    dctl.rd = accept || ((state_q == ST_LOOK) && go_binv && (l2_src[l2_vway] == SRC_DATA))
              || ((state_q == ST_REREAD) && mode_q);
    ictl.hit_wr  = (state_q == ST_LOOK) && l1hit_c && !mode_q;
    dctl.hit_wr  = (state_q == ST_LOOK) && l1hit_c && mode_q;
    ictl.inv_wr  = (state_q == ST_BINV) && (vsrc_q == SRC_INSTR);
    dctl.inv_wr  = (state_q == ST_BINV) && (vsrc_q == SRC_DATA);
    ictl.fill_wr = (state_q == ST_FILL) && !mode_q;
    dctl.fill_wr = (state_q == ST_FILL) && mode_q;
  end

  always_comb begin
    unique case (state_q)
      ST_IDLE: begin
        i_raddr = req_i.address;
        d_raddr = req_i.address;
      end
      ST_LOOK: begin
        i_raddr = vaddr_c;
        d_raddr = vaddr_c;
      end
      default: begin
        i_raddr = addr_q;
        d_raddr = addr_q;
      end
    endcase
    i_addr = ((state_q == ST_BINV) && (vsrc_q == SRC_INSTR)) ? vaddr_q : addr_q;
    d_addr = ((state_q == ST_BINV) && (vsrc_q == SRC_DATA)) ? vaddr_q : addr_q;
  end

  tlc_l1 #(
    .SETS (I_SETS),
    .WAYS (I_WAYS)
  ) u_il1 (
    .clk_i   (clk_i),
    .off_i   (off),
    .raddr_i (i_raddr),
    .addr_i  (i_addr),
    .ctl_i   (ictl),
    .hit_o   (i_hit)
  );

  tlc_l1 #(
    .SETS (D_SETS),
    .WAYS (D_WAYS)
  ) u_dl1 (
    .clk_i   (clk_i),
    .off_i   (off),
    .raddr_i (d_raddr),
    .addr_i  (d_addr),
    .ctl_i   (dctl),
    .hit_o   (d_hit)
  );

  // Sequencer.
  assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + CLR_W'(1);
        if (32'(clr_q) == 32'(MAXR - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (l1hit_c) begin
          state_d = ST_DONE;
        end else if (go_binv) begin
          state_d = ST_BINV;
        end else if (l1en) begin
          state_d = ST_FILL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_BINV:   state_d = l1en ? ST_REREAD : ST_DONE;
      ST_REREAD: state_d = ST_FILL;
      ST_FILL:   state_d = ST_DONE;
      ST_DONE: begin
        if (rsp_load) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Per-access results.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= req_i.address;
      mode_q <= req_i.mode;
      binv_q <= 1'b0;
    end
    if (state_q == ST_LOOK) begin
      time_q   <= time_c;
      l1hit_q  <= l1hit_c;
      l2used_q <= !l1hit_c;
      l2hit_q  <= !l1hit_c && l2_hit;
      vaddr_q  <= vaddr_c;
      vsrc_q   <= l2_src[l2_vway];
    end
    if (state_q == ST_BINV) begin
      binv_q <= (vsrc_q == SRC_INSTR) ? i_hit : d_hit;
    end
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_time_q   <= time_q;
      rsp_l1hit_q  <= l1hit_q;
      rsp_l2used_q <= l2used_q;
      rsp_l2hit_q  <= l2hit_q;
      rsp_binv_q   <= binv_q;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.access_time      = rsp_time_q;
  assign rsp_o.l1_hit           = rsp_l1hit_q;
  assign rsp_o.l2_used          = rsp_l2used_q;
  assign rsp_o.l2_hit           = rsp_l2hit_q;
  assign rsp_o.back_invalidated = rsp_binv_q;

endmodule

`default_nettype wire

FILE: design/tlc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module tlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/tlc_l1.sv
// One L1 tag array: set rows in a RAM with lookup, LRU update, fill and invalidation.
`default_nettype none

module tlc_l1 import tlc_pkg::*; #(
  parameter int SETS = 64,
  parameter int WAYS = 4
) (
  input  wire logic              clk_i,
  input  wire logic [2:0]        off_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire tlc_l1_ctl_t       ctl_i,
  output      logic              hit_o
);

  localparam int SB   = $clog2(SETS + 1) - 1;
  localparam int ROWS = 1 << SB;
  localparam int RAW  = (SB > 0) ? SB : 1;
  localparam int AW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TW   = ADDR_W - 2 - SB;
  localparam int EW   = 1 + AW + TW;
  localparam int RW   = WAYS * EW;
  localparam logic [ADDR_W-1:0] SMASK = (ADDR_W'(1) << SB) - ADDR_W'(1);

  logic [RW-1:0]  rdata, wdata;
  logic           we;
  logic [RAW-1:0] rrow, orow, wrow;
  logic [TW-1:0]  otag;
  logic [WAYS-1:0] vld, mt, nvld;
  logic [AW-1:0]  age [WAYS];
  logic [AW-1:0]  nage [WAYS];
  logic [TW-1:0]  etag [WAYS];
  logic [TW-1:0]  ntag [WAYS];
  logic [AW-1:0]  hway, vway, sel;

  function automatic logic [RAW-1:0] row_of(logic [ADDR_W-1:0] a, logic [2:0] off);
    logic [ADDR_W-1:0] s;
    s = (a >> off) & SMASK;
    return s[RAW-1:0];
  endfunction

  assign rrow = row_of(raddr_i, off_i);
  assign orow = row_of(addr_i, off_i);
  assign otag = TW'(addr_i >> (32'(off_i) + 32'(SB)));

  // Unpack the row and compare the tags of every way.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      vld[w]  = rdata[w*EW + EW - 1];
      age[w]  = rdata[w*EW + TW +: AW];
      etag[w] = rdata[w*EW +: TW];
      mt[w]   = vld[w] && (etag[w] == otag);
    end
  end

  assign hit_o = |mt;

  // Matching way, and the fill victim: first invalid way, else the oldest.
  always_comb begin
    hway = '0;
    vway = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (mt[w]) begin
        hway = AW'(w);
      end
      if (age[w] == '0) begin
        vway = AW'(w);
      end
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!vld[w]) begin
        vway = AW'(w);
      end
    end
  end

  // Build the row to write back.
  always_comb begin
    nvld = vld;
    ntag = etag;
    nage = age;
    sel  = ctl_i.fill_wr ? vway : hway;
    if (ctl_i.hit_wr || ctl_i.fill_wr) begin
      for (int j = 0; j < WAYS; j++) begin
        if (age[j] > age[sel]) begin
          nage[j] = age[j] - AW'(1);
        end
      end
      nage[sel] = AW'(WAYS - 1);
    end
    if (ctl_i.fill_wr) begin
      ntag[sel] = otag;
      nvld[sel] = 1'b1;
    end
    if (ctl_i.inv_wr) begin
      nvld[hway] = 1'b0;
    end
    if (ctl_i.clr) begin
      for (int j = 0; j < WAYS; j++) begin
        nvld[j] = 1'b0;
        ntag[j] = '0;
        nage[j] = AW'(j);
      end
    end
    for (int j = 0; j < WAYS; j++) begin
      wdata[j*EW +: EW] = {nvld[j], nage[j], ntag[j]};
    end
  end

  assign we = (ctl_i.clr && (32'(ctl_i.clr_row) < 32'(ROWS))) || ctl_i.hit_wr ||
              ctl_i.fill_wr || (ctl_i.inv_wr && hit_o);
  assign wrow = ctl_i.clr ? ctl_i.clr_row[RAW-1:0] : orow;

  tlc_ram #(
    .WIDTH (RW),
    .DEPTH (ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wrow),
    .wdata_i (wdata),
    .re_i    (ctl_i.rd),
    .raddr_i (rrow),
    .rdata_o (rdata)
  );

endmodule

`default_nettype wire
